// ===== src/dos_pkg.sv =====
// ----------------------------------------------------------------------------
// dos_pkg
// Shared widths, defaults and control types for the depth order sorter.
// ----------------------------------------------------------------------------
package dos_pkg;

    localparam int KEY_W        = 31;
    localparam int OUT_IDX_W    = 6;
    localparam int CAPACITY_DEF = 64;

    typedef struct packed {
        logic load;
        logic drain;
    } cell_ctl_t;

endpackage

// ===== src/dos_if.sv =====
// ----------------------------------------------------------------------------
// dos_in_if / dos_out_if
// Valid/ready channels carrying load words and sorted result words.
// ----------------------------------------------------------------------------
interface dos_in_if;
    import dos_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] depth_key;
    logic             final_item;

    modport source (output valid, output depth_key, output final_item, input ready);
    modport sink   (input valid, input depth_key, input final_item, output ready);
endinterface

interface dos_out_if;
    import dos_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] item_index;
    logic [KEY_W-1:0]     item_key;
    logic                 last_out;
    logic                 overflowed;

    modport source (output valid, output item_index, output item_key, output last_out,
                    output overflowed, input ready);
    modport sink   (input valid, input item_index, input item_key, input last_out,
                    input overflowed, output ready);
endinterface

// ===== src/depth_order_selection_sort.sv =====
// ----------------------------------------------------------------------------
// depth_order_selection_sort
// Stable ascending sort of a set of depth keys, emitting load positions.
// ----------------------------------------------------------------------------
// A load word is taken every cycle and inserted into a row of CAPACITY cells
// that keeps the set sorted as it arrives; each cell compares its key with
// the new one and hands its content to the right neighbor. The word with
// final_item set starts the drain: one result word per cycle leaves the
// head cell while the receiver is ready. No load word is taken while a set
// drains. Words past CAPACITY are dropped and flagged on every result of the
// set.
module depth_order_selection_sort
    import dos_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic      clk,
    input logic      rst_n,
    dos_in_if.sink   item_in,
    dos_out_if.source item_out
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             drain_reg, drain_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;

    logic             in_acc, out_acc, full;
    cell_ctl_t        ctl;

    logic             c_valid [CAPACITY+2];
    logic [KEY_W-1:0] c_key   [CAPACITY+2];
    logic [IDX_W-1:0] c_idx   [CAPACITY+2];
    logic             c_gt    [CAPACITY+1];
    logic [IDX_W+OUT_IDX_W-1:0] idx_ext;

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign in_acc = item_in.valid && item_in.ready;
    assign out_acc = item_out.valid && item_out.ready;

    assign ctl.load  = in_acc && !full;
    assign ctl.drain = out_acc;

    assign c_valid[0]          = 1'b0;
    assign c_key[0]            = '0;
    assign c_idx[0]            = '0;
    assign c_gt[0]             = 1'b0;
    assign c_valid[CAPACITY+1] = 1'b0;
    assign c_key[CAPACITY+1]   = '0;
    assign c_idx[CAPACITY+1]   = '0;

    for (genvar i = 1; i <= CAPACITY; i++)
    begin : g_cell
        dos_cell #(.IDX_W(IDX_W)) u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_key     (item_in.depth_key),
            .new_idx     (count_reg[IDX_W-1:0]),
            .left_gt     (c_gt[i-1]),
            .left_valid  (c_valid[i-1]),
            .left_key    (c_key[i-1]),
            .left_idx    (c_idx[i-1]),
            .right_valid (c_valid[i+1]),
            .right_key   (c_key[i+1]),
            .right_idx   (c_idx[i+1]),
            .gt          (c_gt[i]),
            .valid       (c_valid[i]),
            .key         (c_key[i]),
            .idx         (c_idx[i])
        );
    end

    always_comb
    begin
        drain_next = drain_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        if (in_acc)
        begin
            if (full)
                drop_next = 1'b1;
            else
                count_next = count_reg + 1'b1;
            if (item_in.final_item)
                drain_next = 1'b1;
        end
        if (out_acc && item_out.last_out)
        begin
            drain_next = 1'b0;
            count_next = '0;
            drop_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            drain_reg <= drain_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    assign idx_ext = {{OUT_IDX_W{1'b0}}, c_idx[1]};

    assign item_in.ready       = !drain_reg;
    assign item_out.valid      = drain_reg && c_valid[1];
    assign item_out.item_index = idx_ext[OUT_IDX_W-1:0];
    assign item_out.item_key   = c_key[1];
    assign item_out.last_out   = !c_valid[2];
    assign item_out.overflowed = drop_reg;

    a_no_load_while_drain: assert property (@(posedge clk) disable iff (!rst_n)
        item_out.valid |-> !item_in.ready)
        else $error("load open while results pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_drain_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && item_in.final_item) |=> (drain_reg && c_valid[1]))
        else $error("drain started with empty head cell");

    a_run_ends_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && item_out.last_out) |=> (!drain_reg && count_reg == '0 && !c_valid[1]))
        else $error("set not cleared after last result");

endmodule

// ===== src/dos_cell.sv =====
// ----------------------------------------------------------------------------
// dos_cell
// One slot of the insertion chain: holds a key and its load index, keeps
// the row sorted on load and shifts toward the head while draining.
// ----------------------------------------------------------------------------
module dos_cell
    import dos_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [KEY_W-1:0] new_key,
    input  logic [IDX_W-1:0] new_idx,
    input  logic             left_gt,
    input  logic             left_valid,
    input  logic [KEY_W-1:0] left_key,
    input  logic [IDX_W-1:0] left_idx,
    input  logic             right_valid,
    input  logic [KEY_W-1:0] right_key,
    input  logic [IDX_W-1:0] right_idx,
    output logic             gt,
    output logic             valid,
    output logic [KEY_W-1:0] key,
    output logic [IDX_W-1:0] idx
);

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // strictly greater keeps equal keys in load order
    assign gt = !valid_reg || (key_reg > new_key);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        if (ctl.drain)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            idx_next   = right_idx;
        end
        else if (ctl.load)
        begin
            if (left_gt)
            begin
                valid_next = left_valid;
                key_next   = left_key;
                idx_next   = left_idx;
            end
            else if (gt)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                idx_next   = new_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        idx_reg <= idx_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign idx   = idx_reg;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the depth order sorter: load words go in as sets closed by a
// final word, and every result word (index, key, last, overflow) is compared
// against an in-bench stable selection sort of the same set, or against the
// typed expected word of a directed row. A table of directed sets comes
// first, then random sets under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb
    import dos_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = CAPACITY_DEF;
    localparam int RANDOM_WORDS = 48;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 4 * CAP;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic [KEY_W-1:0]     key;
        logic                 last;
        logic                 ovf;
    } draw_word_t;

    // count words per row, keys descending from key; fin goes on the last one
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [7:0]       count;
        logic             fin;
        logic             typed;
        draw_word_t       want;
    } load_row_t;

    localparam int N_ROWS = 14;
    localparam load_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{31'd0,           8'd1,       1'b1, 1'b1, '{6'd0, 31'd0,           1'b1, 1'b0}},
        '{KEY_MAX,         8'd1,       1'b1, 1'b1, '{6'd0, KEY_MAX,         1'b1, 1'b0}},
        '{31'd5,           8'd1,       1'b0, 1'b0, '0},
        '{31'd3,           8'd1,       1'b0, 1'b0, '0},
        '{31'd5,           8'd1,       1'b0, 1'b0, '0},
        '{31'd0,           8'd1,       1'b0, 1'b0, '0},
        '{KEY_MAX,         8'd1,       1'b0, 1'b0, '0},
        '{31'd3,           8'd1,       1'b1, 1'b0, '0},
        '{KEY_MAX,         8'd2,       1'b0, 1'b0, '0},
        '{KEY_MAX,         8'd1,       1'b1, 1'b0, '0},
        '{31'd1000,        8'(CAP),    1'b1, 1'b0, '0},
        '{KEY_MAX,         8'(CAP + 1), 1'b1, 1'b0, '0},
        '{31'h2AAAAAAA,    8'(CAP + 3), 1'b1, 1'b0, '0},
        '{31'h55555555,    8'd1,       1'b1, 1'b1, '{6'd0, 31'h55555555,    1'b1, 1'b0}}
    };

    logic clk;
    logic rst_n;

    dos_in_if  in_ch ();
    dos_out_if out_ch ();

    depth_order_selection_sort #(
        .CAPACITY (CAP)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (in_ch),
        .item_out (out_ch)
    );

    logic [KEY_W-1:0] held_keys [CAP];
    int unsigned      held_count;
    bit               dropped;
    draw_word_t       sorted_run [$];
    draw_word_t       expected_order [$];
    int unsigned      mismatches;
    int unsigned      burst_left;
    bit               hold_request;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // stable ascending selection sort of the held set, run on the final word
    function automatic void load_word(logic [KEY_W-1:0] key, logic fin);
        bit taken [CAP];
        int best;
        sorted_run.delete();
        if (held_count < CAP)
        begin
            held_keys[held_count] = key;
            held_count++;
        end
        else
            dropped = 1'b1;
        if (!fin)
            return;
        taken = '{default: 1'b0};
        for (int k = 0; k < held_count; k++)
        begin
            best = -1;
            for (int i = 0; i < held_count; i++)
                if (!taken[i] && (best < 0 || held_keys[i] < held_keys[best]))
                    best = i;
            taken[best] = 1'b1;
            sorted_run.push_back('{index: OUT_IDX_W'(best), key: held_keys[best],
                                   last: (k == held_count - 1), ovf: dropped});
        end
        held_count = 0;
        dropped    = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(int mode);
        logic [31:0] r;
        r = $urandom;
        case (mode)
            0: return r[KEY_W-1:0];
            1: return KEY_W'($urandom_range(0, 7));
            2: return KEY_MAX - KEY_W'($urandom_range(0, 3));
            default:
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return KEY_MAX;
                    2: return r[KEY_W-1:0];
                    default: return KEY_W'($urandom_range(0, 15));
                endcase
        endcase
    endfunction

    task automatic send_word(logic [KEY_W-1:0] key, logic fin, logic typed, draw_word_t want);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.depth_key  <= key;
        in_ch.final_item <= fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        load_word(key, fin);
        if (fin && typed)
            expected_order.push_back(want);
        else
            foreach (sorted_run[i])
                expected_order.push_back(sorted_run[i]);
    endtask

    task automatic wait_all_drawn();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_order.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned set_size;
        int          mode;
        bit          paused;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.depth_key  <= '0;
        in_ch.final_item <= 1'b0;
        held_count   = 0;
        dropped      = 1'b0;
        mismatches   = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        sent         = 0;
        paused       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
            for (int j = 0; j < DIRECTED_ROWS[r].count; j++)
                send_word(DIRECTED_ROWS[r].key - KEY_W'(j),
                          DIRECTED_ROWS[r].fin && (j == DIRECTED_ROWS[r].count - 1),
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        wait_all_drawn();

        // receiver goes quiet for a long stretch while loading continues
        hold_request = 1'b1;
        while (sent < RANDOM_WORDS)
        begin
            set_size = ($urandom_range(0, 19) == 0) ? $urandom_range(CAP - 2, CAP + 4)
                                                    : $urandom_range(1, 12);
            mode = $urandom_range(0, 3);
            for (int j = 0; j < set_size; j++)
                send_word(pick_key(mode), (j == set_size - 1), 1'b0, '0);
            sent += set_size;
            if (!paused && sent >= RANDOM_WORDS / 2)
            begin
                wait_all_drawn();
                paused = 1'b1;
            end
        end
        in_ch.valid <= 1'b0;

        while (expected_order.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                case ($urandom_range(0, 3))
                    0:
                    begin
                        out_ch.ready <= 1'b1;
                        repeat ($urandom_range(1, 40)) @(posedge clk);
                    end
                    1:
                    begin
                        n = $urandom_range(4, 30);
                        repeat (n)
                        begin
                            out_ch.ready <= 1'($urandom_range(0, 1));
                            @(posedge clk);
                        end
                    end
                    2:
                    begin
                        out_ch.ready <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge clk);
                    end
                    default:
                    begin
                        n = $urandom_range(2, 20);
                        for (int i = 0; i < n; i++)
                        begin
                            out_ch.ready <= i[0];
                            @(posedge clk);
                        end
                    end
                endcase
        end
    end

    always @(posedge clk)
    begin : watch_results
        draw_word_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_order.size() == 0)
            begin
                $error("unexpected result word: index 0x%0h key 0x%0h",
                       out_ch.item_index, out_ch.item_key);
                mismatches++;
            end
            else
            begin
                w = expected_order.pop_front();
                check_field("item_index", 32'(w.index), 32'(out_ch.item_index));
                check_field("item_key", 32'(w.key), 32'(out_ch.item_key));
                check_field("last_out", 32'(w.last), 32'(out_ch.last_out));
                check_field("overflowed", 32'(w.ovf), 32'(out_ch.overflowed));
            end
        end
    end

    initial
    begin
        for (int c = 0; c < CYCLE_LIMIT; c++)
            @(posedge clk);
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dos_pkg.sv
src/dos_if.sv
src/dos_cell.sv
src/depth_order_selection_sort.sv
tb/tb.sv
